[src/ac_burst_fire_with_zero_cross_watchdog_unit_assert.svh]
// Assertion helpers shared by the checkers of this block.
`ifndef AC_BURST_FIRE_WITH_ZERO_CROSS_WATCHDOG_UNIT_ASSERT_SVH
`define AC_BURST_FIRE_WITH_ZERO_CROSS_WATCHDOG_UNIT_ASSERT_SVH

// Clocked assertion, off while reset is held.
`define ABFW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("abfw assertion failed");

// Clocked assertion that also holds across reset.
`define ABFW_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("abfw assertion failed");

`endif

[src/abfw_pkg.sv]
package abfw_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned FREQ_W   = 10;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned SEEN_W   = 32;
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned CFG_W    = 16;
  // threshold = 500 * (seen + 2), needs seen width + 10 bits
  localparam int unsigned THR_W    = SEEN_W + 10;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(100);
  localparam logic [FREQ_W-1:0]   FREQ_RST   = FREQ_W'(50);
  localparam logic [SEEN_W:0]     WD_SLACK   = (SEEN_W+1)'(1);

  localparam logic [1:0] FUNC_CROSS = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_SET   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_CONTROL_PERIOD = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MAINS_FREQ     = 1'b1;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_FAULT   = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [TICK_W-1:0] now_ticks;
    logic [CNT_W-1:0]  on_count;
  } item_t;

  typedef struct packed {
    logic    gate_on;
    status_e status;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0] now_ticks;
    logic [TICK_W-1:0] last_ticks;
    logic [SEEN_W-1:0] seen;
    logic [FREQ_W-1:0] freq;
  } wd_req_t;

endpackage

[src/abfw_if.sv]
interface abfw_in_if import abfw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [TICK_W-1:0] now_ticks;
  logic [CNT_W-1:0]  on_count;

  modport source (output valid, func, now_ticks, on_count, input ready);
  modport sink   (input valid, func, now_ticks, on_count, output ready);
endinterface

interface abfw_out_if import abfw_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    gate_on;
  status_e status;

  modport source (output valid, gate_on, status, input ready);
  modport sink   (input valid, gate_on, status, output ready);
endinterface

[src/ac_burst_fire_with_zero_cross_watchdog_unit.sv]
// Burst-fire AC switch with a zero detector watchdog. Each input word is a
// zero crossing, a millisecond tick update or a new on-count, and each gives
// exactly one result word with the gate level and status after it. One word
// is taken every clock while the output is not stalled: the word sits in the
// input register while the single state-update pass (its longest path is the
// 32x10 tick-delta multiply and the threshold compare) computes its result,
// and the output register loads that result when the word advances. The
// output register lets a new word in while a result waits. Configuration
// writes take effect on the next clock.
module ac_burst_fire_with_zero_cross_watchdog_unit import abfw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  abfw_in_if.sink              in_w,
  abfw_out_if.source           out_w
);

  logic    in_vld_q, in_vld_d;
  item_t   in_q;
  logic    out_vld_q, out_vld_d;
  result_t out_q;
  logic    advance;
  logic    in_take;
  wd_req_t wd_req;
  logic    wd_trip;
  result_t res;

  assign advance    = in_vld_q && (!out_vld_q || out_w.ready);
  assign in_w.ready = !in_vld_q || advance;
  assign in_take    = in_w.valid && in_w.ready;
  assign in_vld_d   = in_take || (in_vld_q && !advance);
  assign out_vld_d  = advance || (out_vld_q && !out_w.ready);

  abfw_wdog u_wdog (
    .req_i  (wd_req),
    .trip_o (wd_trip)
  );

  abfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (advance),
    .item_i     (in_q),
    .wd_req_o   (wd_req),
    .wd_trip_i  (wd_trip),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers: load on handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.func      <= in_w.func;
      in_q.now_ticks <= in_w.now_ticks;
      in_q.on_count  <= in_w.on_count;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_w.valid   = out_vld_q;
  assign out_w.gate_on = out_q.gate_on;
  assign out_w.status  = out_q.status;

endmodule

[src/abfw_wdog.sv]
module abfw_wdog import abfw_pkg::*; (
  input  wd_req_t req_i,
  output logic    trip_o
);

  logic [TICK_W-1:0] delta;
  logic [TICK_W-1:0] prod;
  logic [SEEN_W:0]   need;
  logic [THR_W-1:0]  need_w;
  logic [THR_W-1:0]  thr;

  assign delta = req_i.now_ticks - req_i.last_ticks;
  assign prod  = delta * TICK_W'(req_i.freq);

  // floor(prod/500) > seen + 1  <=>  prod >= 500 * (seen + 2)
  assign need   = {1'b0, req_i.seen} + WD_SLACK + WD_SLACK;
  assign need_w = THR_W'(need);
  // 500 = 512 - 8 - 4
  assign thr    = (need_w << 9) - (need_w << 3) - (need_w << 2);

  assign trip_o = (req_i.last_ticks != '0) && (THR_W'(prod) >= thr);

endmodule

[src/abfw_ctrl.sv]
module abfw_ctrl import abfw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 fire_i,
  input  item_t                item_i,
  output wd_req_t              wd_req_o,
  input  logic                 wd_trip_i,
  output result_t              res_o
);

  logic [PERIOD_W-1:0] period_q;
  logic [FREQ_W-1:0]   freq_q;
  logic [PERIOD_W-1:0] phase_q, phase_d;
  logic [SEEN_W-1:0]   seen_q, seen_d;
  logic [TICK_W-1:0]   last_q, last_d;
  logic [CNT_W-1:0]    limit_q, limit_d;
  logic                gate_q, gate_d;
  status_e             status_q, status_d;
  logic [PERIOD_W:0]   phase_nxt;

  assign wd_req_o.now_ticks  = item_i.now_ticks;
  assign wd_req_o.last_ticks = last_q;
  assign wd_req_o.seen       = seen_q;
  assign wd_req_o.freq       = freq_q;

  assign phase_nxt = {1'b0, phase_q} + (PERIOD_W+1)'(1);

  always_comb begin
    phase_d  = phase_q;
    seen_d   = seen_q;
    last_d   = last_q;
    limit_d  = limit_q;
    gate_d   = gate_q;
    status_d = status_q;
    if (fire_i) begin
      unique case (item_i.func)
        FUNC_CROSS: begin
          seen_d = seen_q + SEEN_W'(1);
          gate_d = (phase_q < limit_q);
          // wrap at the period end; a zero period pins the phase at zero
          phase_d = (phase_nxt >= {1'b0, period_q}) ? '0 : phase_nxt[PERIOD_W-1:0];
        end
        FUNC_TICK: begin
          if (wd_trip_i) begin
            gate_d   = 1'b0;
            limit_d  = '0;
            status_d = ST_FAULT;
          end
          seen_d = '0;
          last_d = item_i.now_ticks;
        end
        FUNC_SET: begin
          limit_d  = item_i.on_count;
          status_d = ST_RUNNING;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o.gate_on = gate_d;
  assign res_o.status  = status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      freq_q   <= FREQ_RST;
      phase_q  <= '0;
      seen_q   <= '0;
      last_q   <= '0;
      limit_q  <= '0;
      gate_q   <= 1'b0;
      status_q <= ST_STOPPED;
    end else begin
      phase_q  <= phase_d;
      seen_q   <= seen_d;
      last_q   <= last_d;
      limit_q  <= limit_d;
      gate_q   <= gate_d;
      status_q <= status_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CONTROL_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
          REG_MAINS_FREQ:     freq_q   <= cfg_data_i[FREQ_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[src/abfw_checker.sv]
`include "ac_burst_fire_with_zero_cross_watchdog_unit_assert.svh"

module abfw_checker import abfw_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       gate_on_i,
  input logic [1:0] status_i
);

  // gate conducts only while running: stop and fault both leave on-count zero
  `ABFW_ASSERT(a_gate_needs_run, clk_i, rst_ni, out_valid_i && (status_i != ST_RUNNING) |-> !gate_on_i)

  // no stale word right out of reset
  `ABFW_ASSERT_NR(a_quiet_after_rst, clk_i, $rose(rst_ni) |-> !out_valid_i)

  `ABFW_ASSERT(a_out_hold_valid, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)

  `ABFW_ASSERT(a_out_hold_data, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(gate_on_i) && $stable(status_i))

endmodule

bind ac_burst_fire_with_zero_cross_watchdog_unit abfw_checker u_abfw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_w.valid),
  .out_ready_i (out_w.ready),
  .gate_on_i   (out_w.gate_on),
  .status_i    (out_w.status)
);
